FILE: src/wkstr_pkg.sv
package wkstr_pkg;

   localparam int DATA_W          = 32;
   localparam int MAX_STOPS_DEF   = 16;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int CSR_IDX_W       = 3;
   localparam int STOP_COUNT_W    = 5;
   localparam int STOP_INDEX_W    = 4;
   localparam int LANES           = 4;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_X   = 3'd0,
      CSR_WEIGHT_Y   = 3'd1,
      CSR_WEIGHT_Z   = 3'd2,
      CSR_WEIGHT_W   = 3'd3,
      CSR_KEY_LOW    = 3'd4,
      CSR_KEY_HIGH   = 3'd5,
      CSR_STOP_COUNT = 3'd6
   } csr_idx_type;

   typedef logic [LANES-1:0][DATA_W-1:0] quad_type;

   typedef struct packed {
      logic                      cmd;
      logic [STOP_INDEX_W-1:0]   stop_index;
      logic signed [DATA_W-1:0]  lane_x;
      logic signed [DATA_W-1:0]  lane_y;
      logic signed [DATA_W-1:0]  lane_z;
      logic signed [DATA_W-1:0]  lane_w;
      logic signed [DATA_W-1:0]  old_x;
      logic signed [DATA_W-1:0]  old_y;
      logic signed [DATA_W-1:0]  old_z;
      logic signed [DATA_W-1:0]  old_w;
      logic signed [DATA_W-1:0]  mask_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  res_x;
      logic signed [DATA_W-1:0]  res_y;
      logic signed [DATA_W-1:0]  res_z;
      logic signed [DATA_W-1:0]  res_w;
      logic                      wrote;
   } rsp_type;

   // sideband that rides along the divider
   typedef struct packed {
      logic    u_zero;
      logic    u_one;
      req_type req;
   } div_side_type;

   function automatic quad_type src_quad(input req_type r);
      src_quad = {r.lane_w, r.lane_z, r.lane_y, r.lane_x};
   endfunction

   function automatic quad_type old_quad(input req_type r);
      old_quad = {r.old_w, r.old_z, r.old_y, r.old_x};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647)
         sat32 = 32'sh7fffffff;
      else if (v < -40'sd2147483648)
         sat32 = 32'sh80000000;
      else
         sat32 = v[DATA_W-1:0];
   endfunction

endpackage

FILE: src/weighted_key_stop_table_remap.sv
// Remaps one point per clock through a table of four-component stops. A load
// item (cmd 0) writes one stop and gives no result; an evaluate item (cmd 1)
// gives exactly one result, strobed on rsp_strobe for a single cycle when it
// leaves the output register. busy is never raised, so an item may be
// started in every cycle; the key divider is pipelined one quotient bit per
// stage and sets most of the latency. Results cannot be held off: the
// receiver must take each one when strobed. Loads write the stop table at
// the same pipeline point where evaluates read it, so items act in the
// order they were started. The user must write registers through the csr
// port only while no evaluate is in flight; the block does not enforce it.
module weighted_key_stop_table_remap #(
   parameter int MAX_STOPS = wkstr_pkg::MAX_STOPS_DEF,
   parameter int FRAC_BITS = wkstr_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  wkstr_pkg::req_type                 req_data,
   output logic                               rsp_strobe,
   output wkstr_pkg::rsp_type                 rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wkstr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wkstr_pkg::DATA_W-1:0]       csr_wdata
);

   localparam int F   = FRAC_BITS;
   localparam int AW  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CW  = $clog2(MAX_STOPS + 1);
   localparam int XW  = F + 1 + CW;
   localparam int SW  = $bits(wkstr_pkg::div_side_type);
   localparam int LW  = F + 34;
   localparam int MW  = F + 35;
   localparam logic [F:0] ONE_FX = (F+1)'(1) << F;

   // ---------------- configuration ----------------
   logic signed [31:0] weight_ff [4];
   logic signed [31:0] key_low_ff, key_high_ff;
   logic [wkstr_pkg::STOP_COUNT_W-1:0] stop_count_ff;
   logic [CW-1:0] n_cnt, nm1;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff[0]  <= 32'(ONE_FX);
         weight_ff[1]  <= '0;
         weight_ff[2]  <= '0;
         weight_ff[3]  <= '0;
         key_low_ff    <= '0;
         key_high_ff   <= 32'(ONE_FX);
         stop_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (wkstr_pkg::csr_idx_type'(csr_index))
            wkstr_pkg::CSR_WEIGHT_X:   weight_ff[0]  <= csr_wdata;
            wkstr_pkg::CSR_WEIGHT_Y:   weight_ff[1]  <= csr_wdata;
            wkstr_pkg::CSR_WEIGHT_Z:   weight_ff[2]  <= csr_wdata;
            wkstr_pkg::CSR_WEIGHT_W:   weight_ff[3]  <= csr_wdata;
            wkstr_pkg::CSR_KEY_LOW:    key_low_ff    <= csr_wdata;
            wkstr_pkg::CSR_KEY_HIGH:   key_high_ff   <= csr_wdata;
            wkstr_pkg::CSR_STOP_COUNT: stop_count_ff <= csr_wdata[wkstr_pkg::STOP_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(stop_count_ff) > 32'(MAX_STOPS))
         n_cnt = CW'(MAX_STOPS);
      else
         n_cnt = CW'(stop_count_ff);
      nm1 = n_cnt - CW'(1);
   end

   logic accept;
   assign accept = start && !busy;

   // ---------------- stage 0: weight products ----------------
   logic                  s0_v_ff;
   wkstr_pkg::req_type    s0_req_ff;
   logic signed [63:0]    s0_prod_ff [4];
   wkstr_pkg::quad_type   in_src;

   assign in_src = wkstr_pkg::src_quad(req_data);

   // ---------------- stage 1: key sum ----------------
   logic                  s1_v_ff;
   wkstr_pkg::req_type    s1_req_ff;
   logic signed [65:0]    s1_key_ff;
   logic signed [65:0]    key_in;

   always_comb begin
      key_in = '0;
      for (int k = 0; k < 4; k++) begin
         key_in = key_in + 66'(s0_prod_ff[k] >>> F);
      end
   end

   // ---------------- stage 2: normalize against the key range ----------------
   logic                  s2_v_ff;
   wkstr_pkg::div_side_type s2_side_ff, s2_side_in;
   logic [31:0]           s2_num_ff, s2_den_ff;
   logic signed [32:0]    dd;
   logic signed [32:0]    dabs;
   logic signed [66:0]    num_raw;
   logic signed [67:0]    numf;

   always_comb begin
      dd      = 33'(key_high_ff) - 33'(key_low_ff);
      num_raw = 67'(s1_key_ff) - 67'(key_low_ff);
      dabs    = dd[32] ? -dd : dd;
      numf    = dd[32] ? -68'(num_raw) : 68'(num_raw);
      s2_side_in.req    = s1_req_ff;
      s2_side_in.u_zero = (dd == 33'sd0) || (numf <= 68'sd0);
      s2_side_in.u_one  = (numf >= 68'(dabs));
   end

   // ---------------- divider ----------------
   logic                    dv_v;
   logic [F-1:0]            dv_q;
   logic [SW-1:0]           dv_side_raw;
   wkstr_pkg::div_side_type dv_side;

   wkstr_div #(
      .QW (F),
      .SW (SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff),
      .num       (s2_num_ff),
      .den       (s2_den_ff),
      .side_i    (s2_side_ff),
      .out_valid (dv_v),
      .quo       (dv_q),
      .side_o    (dv_side_raw)
   );

   assign dv_side = wkstr_pkg::div_side_type'(dv_side_raw);

   // ---------------- stage 3: scaled position, table access ----------------
   logic                  s3_v_ff;
   wkstr_pkg::req_type    s3_req_ff;
   logic [XW-1:0]         s3_x_ff;
   logic [F:0]            u_val;
   logic [XW-F-1:0]       i0_raw;
   logic [CW-1:0]         i0, i1;
   logic                  load_we;
   logic [AW-1:0]         load_addr;

   always_comb begin
      if (dv_side.u_zero)
         u_val = '0;
      else if (dv_side.u_one)
         u_val = ONE_FX;
      else
         u_val = {1'b0, dv_q};
   end

   always_comb begin
      i0_raw = s3_x_ff[XW-1:F];
      if (32'(i0_raw) > 32'(nm1))
         i0 = nm1;
      else
         i0 = CW'(i0_raw);
      if (32'(i0) + 32'd1 < 32'(n_cnt))
         i1 = i0 + CW'(1);
      else
         i1 = nm1;
      load_we   = s3_v_ff && (s3_req_ff.cmd == wkstr_pkg::CMD_LOAD)
                  && (32'(s3_req_ff.stop_index) < 32'(MAX_STOPS));
      load_addr = AW'(s3_req_ff.stop_index);
   end

   wkstr_pkg::quad_type stop_mem [MAX_STOPS];

   // ---------------- stage 4: stop pair read ----------------
   logic                  s4_v_ff;
   wkstr_pkg::req_type    s4_req_ff;
   logic [F-1:0]          s4_f_ff;
   wkstr_pkg::quad_type   s4_a_ff, s4_b_ff;

   always_ff @(posedge clock) begin
      if (load_we) begin
         stop_mem[load_addr] <= wkstr_pkg::src_quad(s3_req_ff);
      end
      s4_a_ff <= stop_mem[AW'(i0)];
      s4_b_ff <= stop_mem[AW'(i1)];
   end

   // ---------------- stage 5: stop lerp product ----------------
   logic                  s5_v_ff;
   wkstr_pkg::req_type    s5_req_ff;
   wkstr_pkg::quad_type   s5_a_ff;
   logic signed [LW-1:0]  s5_prod_ff [4];
   logic signed [LW-1:0]  lerp_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lerp_in[k] = LW'(33'($signed(s4_b_ff[k])) - 33'($signed(s4_a_ff[k])))
                      * LW'($signed({1'b0, s4_f_ff}));
      end
   end

   // ---------------- stage 6: interpolated value, mask clamp ----------------
   logic                  s6_v_ff;
   wkstr_pkg::req_type    s6_req_ff;
   wkstr_pkg::quad_type   s6_nv_ff, nv_in;
   logic [F:0]            s6_m_ff, m_in;
   logic signed [LW-1:0]  lerp_sh [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lerp_sh[k] = s5_prod_ff[k] >>> F;
         nv_in[k]   = wkstr_pkg::sat32(40'($signed(s5_a_ff[k])) + 40'(lerp_sh[k]));
      end
      if (s5_req_ff.mask_value < 32'sd0)
         m_in = '0;
      else if (s5_req_ff.mask_value > $signed(32'(ONE_FX)))
         m_in = ONE_FX;
      else
         m_in = s5_req_ff.mask_value[F:0];
   end

   // ---------------- stage 7: mask blend product ----------------
   logic                  s7_v_ff;
   wkstr_pkg::req_type    s7_req_ff;
   wkstr_pkg::quad_type   s7_nv_ff, old6, old7;
   logic [F:0]            s7_m_ff;
   logic signed [MW-1:0]  s7_mprod_ff [4];
   logic signed [MW-1:0]  mprod_in [4];

   assign old6 = wkstr_pkg::old_quad(s6_req_ff);
   assign old7 = wkstr_pkg::old_quad(s7_req_ff);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mprod_in[k] = MW'(33'($signed(s6_nv_ff[k])) - 33'($signed(old6[k])))
                       * MW'($signed({1'b0, s6_m_ff}));
      end
   end

   // ---------------- output ----------------
   logic                  rsp_strobe_ff;
   wkstr_pkg::rsp_type    rsp_ff, rsp_in;
   wkstr_pkg::quad_type   res_q;
   logic signed [MW-1:0]  blend_sh [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         blend_sh[k] = s7_mprod_ff[k] >>> F;
         if (n_cnt == '0)
            res_q[k] = old7[k];
         else if (s7_m_ff == ONE_FX)
            res_q[k] = s7_nv_ff[k];
         else
            res_q[k] = wkstr_pkg::sat32(40'($signed(old7[k])) + 40'(blend_sh[k]));
      end
      rsp_in.res_x = res_q[0];
      rsp_in.res_y = res_q[1];
      rsp_in.res_z = res_q[2];
      rsp_in.res_w = res_q[3];
      rsp_in.wrote = (n_cnt != '0);
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff       <= 1'b0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         s3_v_ff       <= 1'b0;
         s4_v_ff       <= 1'b0;
         s5_v_ff       <= 1'b0;
         s6_v_ff       <= 1'b0;
         s7_v_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s0_v_ff       <= accept;
         s1_v_ff       <= s0_v_ff;
         s2_v_ff       <= s1_v_ff;
         s3_v_ff       <= dv_v;
         s4_v_ff       <= s3_v_ff && (s3_req_ff.cmd == wkstr_pkg::CMD_EVAL);
         s5_v_ff       <= s4_v_ff;
         s6_v_ff       <= s5_v_ff;
         s7_v_ff       <= s6_v_ff;
         rsp_strobe_ff <= s7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_req_ff <= req_data;
      for (int k = 0; k < 4; k++) begin
         s0_prod_ff[k] <= 64'($signed(in_src[k])) * 64'(weight_ff[k]);
      end
      s1_req_ff  <= s0_req_ff;
      s1_key_ff  <= key_in;
      s2_side_ff <= s2_side_in;
      s2_num_ff  <= numf[31:0];
      s2_den_ff  <= dabs[31:0];
      s3_req_ff  <= dv_side.req;
      s3_x_ff    <= XW'(u_val) * XW'(nm1);
      s4_req_ff  <= s3_req_ff;
      s4_f_ff    <= s3_x_ff[F-1:0];
      s5_req_ff  <= s4_req_ff;
      s5_a_ff    <= s4_a_ff;
      for (int k = 0; k < 4; k++) begin
         s5_prod_ff[k]  <= lerp_in[k];
         s7_mprod_ff[k] <= mprod_in[k];
      end
      s6_req_ff  <= s5_req_ff;
      s6_nv_ff   <= nv_in;
      s6_m_ff    <= m_in;
      s7_req_ff  <= s6_req_ff;
      s7_nv_ff   <= s6_nv_ff;
      s7_m_ff    <= s6_m_ff;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---------------- assertions ----------------
   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(dv_v && (dv_side.req.cmd == wkstr_pkg::CMD_EVAL), 6))
      else $error("result strobe without an evaluate leaving the divider");

   a_no_load_after_table: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff |-> (s4_req_ff.cmd == wkstr_pkg::CMD_EVAL))
      else $error("load transfer passed the table stage");

   a_stage_after_load: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && (s3_req_ff.cmd == wkstr_pkg::CMD_LOAD)) |=> !s4_v_ff)
      else $error("load transfer produced a lerp stage entry");

endmodule

FILE: src/wkstr_div.sv
module wkstr_div #(
   parameter int QW = wkstr_pkg::FRAC_BITS_DEF,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [31:0]   num,
   input  logic [31:0]   den,
   input  logic [SW-1:0] side_i,
   output logic          out_valid,
   output logic [QW-1:0] quo,
   output logic [SW-1:0] side_o
);

   // one quotient bit per stage, num < den keeps the remainder in 32 bits
   logic          v_ff    [QW];
   logic [31:0]   rem_ff  [QW];
   logic [31:0]   den_ff  [QW];
   logic [QW-1:0] q_ff    [QW];
   logic [SW-1:0] side_ff [QW];

   genvar k;
   generate
      for (k = 0; k < QW; k++) begin : g_stage
         logic          v_in;
         logic [31:0]   rem_src;
         logic [31:0]   den_src;
         logic [QW-1:0] q_src;
         logic [SW-1:0] side_src;
         logic [32:0]   r2;
         logic          ge;

         if (k == 0) begin : g_first
            assign v_in     = in_valid;
            assign rem_src  = num;
            assign den_src  = den;
            assign q_src    = '0;
            assign side_src = side_i;
         end else begin : g_next
            assign v_in     = v_ff[k-1];
            assign rem_src  = rem_ff[k-1];
            assign den_src  = den_ff[k-1];
            assign q_src    = q_ff[k-1];
            assign side_src = side_ff[k-1];
         end

         assign r2 = {rem_src, 1'b0};
         assign ge = (r2 >= {1'b0, den_src});

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else begin
               v_ff[k] <= v_in;
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[k]  <= ge ? 32'(r2 - {1'b0, den_src}) : r2[31:0];
            den_ff[k]  <= den_src;
            q_ff[k]    <= {q_src[QW-2:0], ge};
            side_ff[k] <= side_src;
         end
      end
   endgenerate

   assign out_valid = v_ff[QW-1];
   assign quo       = q_ff[QW-1];
   assign side_o    = side_ff[QW-1];

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int FRAC = wkstr_pkg::FRAC_BITS_DEF;
   localparam int DW = wkstr_pkg::DATA_W;
   localparam int NSTOP = wkstr_pkg::MAX_STOPS_DEF;
   localparam int SIDX_W = wkstr_pkg::STOP_INDEX_W;
   localparam int NUM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 3000;

   class remap_scoreboard;
      longint weight [4];
      longint key_low;
      longint key_high;
      int unsigned stop_count;
      logic signed [DW-1:0] stops [NSTOP][4];
      wkstr_pkg::rsp_type expected_q [$];
      int errors;

      function new();
         weight[0] = longint'(1) << FRAC;
         weight[1] = 0;
         weight[2] = 0;
         weight[3] = 0;
         key_low = 0;
         key_high = longint'(1) << FRAC;
         stop_count = 0;
         errors = 0;
      endfunction

      function void write_reg(wkstr_pkg::csr_idx_type idx, logic [DW-1:0] data);
         case (idx)
            wkstr_pkg::CSR_WEIGHT_X:   weight[0] = longint'($signed(data));
            wkstr_pkg::CSR_WEIGHT_Y:   weight[1] = longint'($signed(data));
            wkstr_pkg::CSR_WEIGHT_Z:   weight[2] = longint'($signed(data));
            wkstr_pkg::CSR_WEIGHT_W:   weight[3] = longint'($signed(data));
            wkstr_pkg::CSR_KEY_LOW:    key_low = longint'($signed(data));
            wkstr_pkg::CSR_KEY_HIGH:   key_high = longint'($signed(data));
            wkstr_pkg::CSR_STOP_COUNT:
               stop_count = 32'(data[wkstr_pkg::STOP_COUNT_W-1:0]);
            default: ;
         endcase
      endfunction

      function logic signed [DW-1:0] clip(longint v);
         if (v > 64'sd2147483647)
            return 32'sh7fffffff;
         if (v < -64'sd2147483648)
            return 32'sh80000000;
         return v[DW-1:0];
      endfunction

      function logic signed [DW-1:0] mix(longint a, longint b, longint f);
         return clip(a + (((b - a) * f) >>> FRAC));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // called on every accepted input transfer
      function void note_item(wkstr_pkg::req_type r);
         longint lanes [4];
         longint olds [4];
         longint key, span, num, pos, frac, mask, one;
         int unsigned n, i0, i1;
         wkstr_pkg::rsp_type e;
         lanes[0] = longint'(r.lane_x); lanes[1] = longint'(r.lane_y);
         lanes[2] = longint'(r.lane_z); lanes[3] = longint'(r.lane_w);
         olds[0] = longint'(r.old_x); olds[1] = longint'(r.old_y);
         olds[2] = longint'(r.old_z); olds[3] = longint'(r.old_w);
         one = longint'(1) << FRAC;
         if (r.cmd == wkstr_pkg::CMD_LOAD) begin
            for (int k = 0; k < 4; k++)
               stops[r.stop_index][k] = lanes[k][DW-1:0];
            return;
         end
         n = (stop_count > NSTOP) ? NSTOP : stop_count;
         e.wrote = (n != 0);
         if (n == 0) begin
            e.res_x = r.old_x; e.res_y = r.old_y;
            e.res_z = r.old_z; e.res_w = r.old_w;
         end else begin
            key = 0;
            for (int k = 0; k < 4; k++)
               key += (lanes[k] * weight[k]) >>> FRAC;
            span = key_high - key_low;
            num = key - key_low;
            if (span < 0) begin
               span = -span;
               num = -num;
            end
            if (span == 0 || num <= 0)
               pos = 0;
            else if (num >= span)
               pos = one;
            else
               pos = (num << FRAC) / span;
            pos = pos * longint'(n - 1);
            i0 = 32'(pos >>> FRAC);
            if (i0 > n - 1)
               i0 = n - 1;
            i1 = (i0 + 1 < n) ? i0 + 1 : n - 1;
            frac = pos & (one - 1);
            mask = longint'(r.mask_value);
            if (mask < 0)
               mask = 0;
            if (mask > one)
               mask = one;
            for (int k = 0; k < 4; k++) begin
               logic signed [DW-1:0] nv;
               nv = mix(stops[i0][k], stops[i1][k], frac);
               if (mask < one)
                  nv = mix(olds[k], nv, mask);
               case (k)
                  0: e.res_x = nv;
                  1: e.res_y = nv;
                  2: e.res_z = nv;
                  default: e.res_w = nv;
               endcase
            end
         end
         expected_q = {expected_q, e};
      endfunction

      function void check_result(wkstr_pkg::rsp_type got);
         wkstr_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: %h", got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.res_x !== e.res_x) begin
            $error("res_x expected %h got %h", e.res_x, got.res_x);
            errors++;
         end
         if (got.res_y !== e.res_y) begin
            $error("res_y expected %h got %h", e.res_y, got.res_y);
            errors++;
         end
         if (got.res_z !== e.res_z) begin
            $error("res_z expected %h got %h", e.res_z, got.res_z);
            errors++;
         end
         if (got.res_w !== e.res_w) begin
            $error("res_w expected %h got %h", e.res_w, got.res_w);
            errors++;
         end
         if (got.wrote !== e.wrote) begin
            $error("wrote expected %b got %b", e.wrote, got.wrote);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   wkstr_pkg::req_type req_data;
   logic rsp_strobe;
   wkstr_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [wkstr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [DW-1:0] csr_wdata;

   remap_scoreboard sb;
   int stall_count;
   int idle_pct;

   weighted_key_stop_table_remap u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("weighted_key_stop_table_remap verification failed");
         $finish;
      end
   end

   task automatic write_csr(wkstr_pkg::csr_idx_type idx, logic [DW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(wkstr_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_item(r);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      // loads may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         2: return $urandom_range(1) ? 32'h0 : 32'hffffffff;
         default: return $urandom_range(1048576) - 524288;
      endcase
   endfunction

   function automatic logic [DW-1:0] pick_mask();
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         2, 3, 4: return $urandom_range(81920) - 8192;
         default: return 32'h00010000;
      endcase
   endfunction

   function automatic wkstr_pkg::req_type random_item();
      wkstr_pkg::req_type r;
      r.cmd = ($urandom_range(99) < 20) ? wkstr_pkg::CMD_LOAD : wkstr_pkg::CMD_EVAL;
      r.stop_index = SIDX_W'($urandom_range(NSTOP - 1));
      r.lane_x = pick_value();
      r.lane_y = pick_value();
      r.lane_z = pick_value();
      r.lane_w = pick_value();
      r.old_x = pick_value();
      r.old_y = pick_value();
      r.old_z = pick_value();
      r.old_w = pick_value();
      r.mask_value = pick_mask();
      return r;
   endfunction

   function automatic wkstr_pkg::req_type eval_item(logic [DW-1:0] x, logic [DW-1:0] m);
      wkstr_pkg::req_type r;
      r = random_item();
      r.cmd = wkstr_pkg::CMD_EVAL;
      r.lane_x = x;
      r.mask_value = m;
      return r;
   endfunction

   task automatic configure(int phase);
      logic [DW-1:0] w [4];
      logic [DW-1:0] lo, hi, cnt;
      for (int k = 0; k < 4; k++)
         w[k] = $urandom_range(262144) - 131072;
      lo = $urandom_range(131072) - 65536;
      hi = lo + $urandom_range(1, 262144);
      cnt = $urandom_range(1, NSTOP);
      if ($urandom_range(3) == 0)
         cnt = $urandom_range(NSTOP + 1, 31);
      case (phase)
         0: begin
            w[0] = 32'h00010000;
            w[1] = 0; w[2] = 0; w[3] = 0;
            lo = 0; hi = 32'h00010000; cnt = NSTOP;
         end
         1: cnt = 0;
         2: hi = lo;
         3: begin
            hi = lo - $urandom_range(1, 262144);
            cnt = 31;
         end
         4: begin
            w[0] = 32'h7fffffff; w[1] = 32'h80000000;
            w[2] = 32'h80000000; w[3] = 32'h7fffffff;
            lo = 32'h80000000; hi = 32'h7fffffff; cnt = 1;
         end
         5: begin
            lo = 32'h7fffffff; hi = 32'h80000000;
         end
         default: ;
      endcase
      write_csr(wkstr_pkg::CSR_WEIGHT_X, w[0]);
      write_csr(wkstr_pkg::CSR_WEIGHT_Y, w[1]);
      write_csr(wkstr_pkg::CSR_WEIGHT_Z, w[2]);
      write_csr(wkstr_pkg::CSR_WEIGHT_W, w[3]);
      write_csr(wkstr_pkg::CSR_KEY_LOW, lo);
      write_csr(wkstr_pkg::CSR_KEY_HIGH, hi);
      write_csr(wkstr_pkg::CSR_STOP_COUNT, cnt);
   endtask

   task automatic directed_items();
      wkstr_pkg::req_type r;
      // fill every stop first so no evaluate reads an unwritten one
      for (int i = 0; i < NSTOP; i++) begin
         r = random_item();
         r.cmd = wkstr_pkg::CMD_LOAD;
         r.stop_index = SIDX_W'(i);
         if (i % 2 == 0) begin
            r.lane_x = 32'h7fffffff; r.lane_y = 32'h80000000;
         end else begin
            r.lane_x = 32'h80000000; r.lane_y = 32'h7fffffff;
         end
         send_item(r);
      end
      send_item(eval_item(32'h0, 32'h00010000));
      send_item(eval_item(32'h00010000, 32'h00010000));
      send_item(eval_item(32'h00008000, 32'h00008000));
      send_item(eval_item(32'h00004321, 32'h0));
      send_item(eval_item(32'hfffe0000, 32'hffff0000));
      send_item(eval_item(32'h00030000, 32'h00020000));
      send_item(eval_item(32'h7fffffff, 32'h7fffffff));
      send_item(eval_item(32'h80000000, 32'h80000000));
      send_item(eval_item(32'h0000c001, 32'h0000ffff));
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      stall_count = 0;
      idle_pct = 19;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_pct = (p < 4) ? 19 : (p < 7) ? 79 : 0;
         configure(p);
         if (p == 0)
            directed_items();
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            send_item(random_item());
         wait_quiet();
      end
      if (sb.errors == 0 && sb.pending() == 0)
         $display("weighted_key_stop_table_remap verification clean");
      else
         $display("weighted_key_stop_table_remap verification failed");
      $finish;
   end

endmodule

FILE: files.f
src/wkstr_pkg.sv
src/wkstr_div.sv
src/weighted_key_stop_table_remap.sv
tb/tb.sv
